// ===== sv/selective_repeat_send_window_assert.svh =====
// Assertion macros shared by the window sender.
`ifndef SELECTIVE_REPEAT_SEND_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_SEND_WINDOW_ASSERT_SVH

// Expression holds at every clock edge outside reset.
`define SRSW_ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("srsw: invariant violated");

// Antecedent at one edge implies consequent at the next edge.
`define SRSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srsw: next-cycle implication violated");

`endif

// ===== sv/srsw_pkg.sv =====
package srsw_pkg;

   localparam int WINDOW_PACKETS_DEF = 10;
   localparam int PAYLOAD_MAX_DEF    = 500;

   localparam int OP_W      = 2;
   localparam int KIND_W    = 2;
   localparam int SEQ_W     = 7;
   localparam int BYTE_W    = 13;
   localparam int LEN_W     = 9;
   localparam int LIMIT_W   = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_BASE     = 2'd1;

   localparam logic [LIMIT_W-1:0] TIMEOUT_LIMIT_RST = 8'd100;
   localparam logic [SEQ_W-1:0]   WRAP_BASE_RST     = 7'd100;
   localparam logic [LIMIT_W-1:0] RUN_MAX           = 8'hFF;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_ACK     = 2'd1,
      OP_TIMEOUT = 2'd2
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_SEND = 2'd0,
      KIND_DONE = 2'd1,
      KIND_DEAD = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCAN
   } state_type;

endpackage

// ===== sv/srsw_req_if.sv =====
interface srsw_req_if;
   logic                        valid;
   logic                        ready;
   logic [srsw_pkg::OP_W-1:0]   opcode;
   logic [srsw_pkg::BYTE_W-1:0] byte_count;
   logic                        final_window;
   logic [srsw_pkg::SEQ_W-1:0]  ack_seq;

   modport source (output valid, opcode, byte_count, final_window, ack_seq, input ready);
   modport sink (input valid, opcode, byte_count, final_window, ack_seq, output ready);
endinterface

// ===== sv/srsw_rsp_if.sv =====
interface srsw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [srsw_pkg::KIND_W-1:0] kind;
   logic [srsw_pkg::SEQ_W-1:0]  seq_number;
   logic [srsw_pkg::BYTE_W-1:0] byte_offset;
   logic [srsw_pkg::LEN_W-1:0]  payload_len;
   logic                        end_of_file;
   logic                        run_last;

   modport source (output valid, kind, seq_number, byte_offset, payload_len, end_of_file,
                   run_last, input ready);
   modport sink (input valid, kind, seq_number, byte_offset, payload_len, end_of_file,
                 run_last, output ready);
endinterface

// ===== sv/srsw_csr_if.sv =====
interface srsw_csr_if;
   logic                           valid;
   logic                           ready;
   logic [srsw_pkg::CSR_IDX_W-1:0] index;
   logic [srsw_pkg::CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/selective_repeat_send_window.sv =====
// Selective-repeat send window. Each req transfer carries one command: load a window (split
// into packets of PAYLOAD_MAX bytes, clamped to WINDOW_PACKETS packets), record an ack, or
// handle an ack-wait timeout (fail, finish the window, or resend every unacked packet).
// Results leave on rsp one transfer at a time through an output register; run_last marks the
// last result of a command. An ack, or a timeout that fails or finishes the window, is handled
// in the idle state alone. A load splits the byte count with a single subtractor that peels
// off one packet per cycle before the scan; a resend scan visits at most WINDOW_PACKETS slots,
// one slot per cycle, stretched by any rsp stall.
// req is not ready while a load divides or a scan runs. csr writes are taken every cycle and
// must only be issued while the block is idle; index 0 is timeout_limit, 1 is wrap_base.
`include "selective_repeat_send_window_assert.svh"

module selective_repeat_send_window #(
   parameter int WINDOW_PACKETS = srsw_pkg::WINDOW_PACKETS_DEF,
   parameter int PAYLOAD_MAX    = srsw_pkg::PAYLOAD_MAX_DEF
) (
   input  logic         clock,
   input  logic         reset,
   srsw_req_if.sink     req,
   srsw_rsp_if.source   rsp,
   srsw_csr_if.sink     csr
);

   localparam int PKT_W  = $clog2(WINDOW_PACKETS + 1);
   localparam int IDX_W  = $clog2(WINDOW_PACKETS);
   localparam int TAIL_W = $clog2(PAYLOAD_MAX + 1);

   localparam logic [31:0] CAP_BYTES = 32'(WINDOW_PACKETS * PAYLOAD_MAX);
   localparam logic [srsw_pkg::BYTE_W-1:0] PM_BYTES = srsw_pkg::BYTE_W'(PAYLOAD_MAX);
   localparam logic [srsw_pkg::LEN_W-1:0]  PM_LEN   = srsw_pkg::LEN_W'(PAYLOAD_MAX);
   localparam logic [srsw_pkg::SEQ_W-1:0]  WP_SEQ   = srsw_pkg::SEQ_W'(WINDOW_PACKETS);
   localparam logic [PKT_W-1:0]            PKT_ONE  = PKT_W'(1);

   // control state
   srsw_pkg::state_type state_ff, state_in;
   logic [srsw_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [srsw_pkg::SEQ_W-1:0]   wrap_ff, wrap_in;
   logic [srsw_pkg::SEQ_W-1:0]   base_ff, base_in;
   logic [WINDOW_PACKETS-1:0]    ack_map_ff, ack_map_in;
   logic [PKT_W-1:0]             acked_ff, acked_in;
   logic [PKT_W-1:0]             total_ff, total_in;
   logic [TAIL_W-1:0]            tail_ff, tail_in;
   logic                         eof_ff, eof_in;
   logic [srsw_pkg::LIMIT_W-1:0] run_ff, run_in;

   // sequencer working registers
   logic [srsw_pkg::BYTE_W-1:0]  rem_ff, rem_in;
   logic [PKT_W-1:0]             scan_ff, scan_in;
   logic [srsw_pkg::BYTE_W-1:0]  offset_ff, offset_in;

   // output register
   logic                         out_valid_ff, out_valid_in;
   srsw_pkg::kind_type           out_kind_ff, out_kind_in;
   logic [srsw_pkg::SEQ_W-1:0]   out_seq_ff, out_seq_in;
   logic [srsw_pkg::BYTE_W-1:0]  out_offset_ff, out_offset_in;
   logic [srsw_pkg::LEN_W-1:0]   out_len_ff, out_len_in;
   logic                         out_eof_ff, out_eof_in;
   logic                         out_last_ff, out_last_in;

   logic out_free;
   logic req_fire;
   logic load_fire;
   logic csr_fire;

   // ack decode
   logic [srsw_pkg::SEQ_W-1:0] ack_diff;
   logic [IDX_W-1:0]           ack_idx;
   logic                       ack_hit;

   // timeout decode
   logic [srsw_pkg::LIMIT_W-1:0] run_inc;
   logic                         timed_out;
   logic                         window_full;
   logic                         timeout_scan;

   // load clamp
   logic [srsw_pkg::BYTE_W-1:0] clamped;

   // scan decode
   logic [WINDOW_PACKETS-1:0] vmask;
   logic [WINDOW_PACKETS-1:0] pend;
   logic [WINDOW_PACKETS-1:0] later;
   logic [IDX_W-1:0]          scan_idx;
   logic                      scan_done;
   logic                      scan_tail;
   logic                      no_later;

   // A slot of the output register is free when empty or being drained this cycle.
   assign out_free  = !out_valid_ff || rsp.ready;
   assign req.ready = (state_ff == srsw_pkg::ST_IDLE) && out_free;
   assign req_fire  = req.valid && req.ready;
   assign load_fire = req_fire && (req.opcode == srsw_pkg::OP_LOAD);
   assign csr.ready = 1'b1;
   assign csr_fire  = csr.valid && csr.ready;

   assign rsp.valid       = out_valid_ff;
   assign rsp.kind        = out_kind_ff;
   assign rsp.seq_number  = out_seq_ff;
   assign rsp.byte_offset = out_offset_ff;
   assign rsp.payload_len = out_len_ff;
   assign rsp.end_of_file = out_eof_ff;
   assign rsp.run_last    = out_last_ff;

   // Ack counts only inside the loaded part of the window and only once per packet.
   assign ack_diff = req.ack_seq - base_ff;
   assign ack_idx  = ack_diff[IDX_W-1:0];
   assign ack_hit  = (req.ack_seq >= base_ff) && (ack_diff < srsw_pkg::SEQ_W'(total_ff))
                     && !ack_map_ff[ack_idx];

   // Saturate the timeout run; compare the advanced count against the limit.
   assign run_inc      = (run_ff == srsw_pkg::RUN_MAX) ? run_ff : run_ff + 8'd1;
   assign timed_out    = run_inc > limit_ff;
   assign window_full  = acked_ff == total_ff;
   assign timeout_scan = (req.opcode == srsw_pkg::OP_TIMEOUT) && !timed_out
                         && (total_ff != '0) && !window_full;

   assign clamped = (32'(req.byte_count) > CAP_BYTES) ? CAP_BYTES[srsw_pkg::BYTE_W-1:0]
                                                       : req.byte_count;

   // Mark the packets that exist in the current window.
   always_comb begin
      for (int j = 0; j < WINDOW_PACKETS; j++) begin
         vmask[j] = PKT_W'(j) < total_ff;
      end
   end

   // A slot is the last result when no unacked packet sits above it.
   assign pend      = ~ack_map_ff & vmask;
   assign later     = pend >> scan_ff;
   assign no_later  = (later >> 1) == '0;
   assign scan_idx  = scan_ff[IDX_W-1:0];
   assign scan_done = scan_ff == total_ff;
   assign scan_tail = (scan_ff + PKT_ONE) == total_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srsw_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req.opcode == srsw_pkg::OP_LOAD) begin
                  state_in = srsw_pkg::ST_DIVIDE;
               end else if (timeout_scan) begin
                  state_in = srsw_pkg::ST_SCAN;
               end
            end
         end
         srsw_pkg::ST_DIVIDE: begin
            if (rem_ff <= PM_BYTES) begin
               state_in = (rem_ff == '0) ? srsw_pkg::ST_IDLE : srsw_pkg::ST_SCAN;
            end
         end
         srsw_pkg::ST_SCAN: begin
            if (out_free && scan_done) begin
               state_in = srsw_pkg::ST_IDLE;
            end
         end
         default: state_in = srsw_pkg::ST_IDLE;
      endcase
   end

   // Datapath and result generation.
   always_comb begin
      limit_in      = limit_ff;
      wrap_in       = wrap_ff;
      base_in       = base_ff;
      ack_map_in    = ack_map_ff;
      acked_in      = acked_ff;
      total_in      = total_ff;
      tail_in       = tail_ff;
      eof_in        = eof_ff;
      run_in        = run_ff;
      rem_in        = rem_ff;
      scan_in       = scan_ff;
      offset_in     = offset_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_kind_in   = out_kind_ff;
      out_seq_in    = out_seq_ff;
      out_offset_in = out_offset_ff;
      out_len_in    = out_len_ff;
      out_eof_in    = out_eof_ff;
      out_last_in   = out_last_ff;

      if (csr_fire) begin
         unique case (csr.index)
            srsw_pkg::CSR_TIMEOUT_LIMIT: limit_in = csr.data[srsw_pkg::LIMIT_W-1:0];
            srsw_pkg::CSR_WRAP_BASE:     wrap_in  = csr.data[srsw_pkg::SEQ_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         srsw_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (srsw_pkg::op_type'(req.opcode))
                  srsw_pkg::OP_LOAD: begin
                     rem_in     = clamped;
                     total_in   = '0;
                     acked_in   = '0;
                     ack_map_in = '0;
                     tail_in    = '0;
                     eof_in     = req.final_window;
                  end
                  srsw_pkg::OP_ACK: begin
                     run_in = '0;
                     if (ack_hit) begin
                        ack_map_in[ack_idx] = 1'b1;
                        acked_in            = acked_ff + PKT_ONE;
                     end
                  end
                  srsw_pkg::OP_TIMEOUT: begin
                     run_in = run_inc;
                     if (timed_out) begin
                        out_valid_in  = 1'b1;
                        out_kind_in   = srsw_pkg::KIND_DEAD;
                        out_seq_in    = '0;
                        out_offset_in = '0;
                        out_len_in    = '0;
                        out_eof_in    = 1'b0;
                        out_last_in   = 1'b1;
                     end else if ((total_ff != '0) && window_full) begin
                        // Report done, then advance or wrap the base and retire the window.
                        out_valid_in  = 1'b1;
                        out_kind_in   = srsw_pkg::KIND_DONE;
                        out_seq_in    = base_ff;
                        out_offset_in = '0;
                        out_len_in    = '0;
                        out_eof_in    = 1'b0;
                        out_last_in   = 1'b1;
                        base_in       = (base_ff == wrap_ff) ? '0 : base_ff + WP_SEQ;
                        total_in      = '0;
                        acked_in      = '0;
                        ack_map_in    = '0;
                     end else if (timeout_scan) begin
                        scan_in   = '0;
                        offset_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         srsw_pkg::ST_DIVIDE: begin
            // Peel one full packet per cycle; the remainder becomes the tail.
            if (rem_ff > PM_BYTES) begin
               rem_in   = rem_ff - PM_BYTES;
               total_in = total_ff + PKT_ONE;
            end else begin
               if (rem_ff != '0) begin
                  total_in = total_ff + PKT_ONE;
                  tail_in  = TAIL_W'(rem_ff);
               end
               scan_in   = '0;
               offset_in = '0;
            end
         end
         srsw_pkg::ST_SCAN: begin
            // Visit one slot per cycle while the output register is free; emit a descriptor for each unacked packet.
            if (out_free && !scan_done) begin
               scan_in   = scan_ff + PKT_ONE;
               offset_in = offset_ff + PM_BYTES;
               if (!ack_map_ff[scan_idx]) begin
                  out_valid_in  = 1'b1;
                  out_kind_in   = srsw_pkg::KIND_SEND;
                  out_seq_in    = base_ff + srsw_pkg::SEQ_W'(scan_ff);
                  out_offset_in = offset_ff;
                  out_len_in    = scan_tail ? srsw_pkg::LEN_W'(tail_ff) : PM_LEN;
                  out_eof_in    = scan_tail && eof_ff;
                  out_last_in   = no_later;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srsw_pkg::ST_IDLE;
         limit_ff     <= srsw_pkg::TIMEOUT_LIMIT_RST;
         wrap_ff      <= srsw_pkg::WRAP_BASE_RST;
         base_ff      <= '0;
         ack_map_ff   <= '0;
         acked_ff     <= '0;
         total_ff     <= '0;
         tail_ff      <= '0;
         eof_ff       <= 1'b0;
         run_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         wrap_ff      <= wrap_in;
         base_ff      <= base_in;
         ack_map_ff   <= ack_map_in;
         acked_ff     <= acked_in;
         total_ff     <= total_in;
         tail_ff      <= tail_in;
         eof_ff       <= eof_in;
         run_ff       <= run_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      scan_ff       <= scan_in;
      offset_ff     <= offset_in;
      out_kind_ff   <= out_kind_in;
      out_seq_ff    <= out_seq_in;
      out_offset_ff <= out_offset_in;
      out_len_ff    <= out_len_in;
      out_eof_ff    <= out_eof_in;
      out_last_ff   <= out_last_in;
   end

   // The ack count always equals the number of marked packets.
   `SRSW_ASSERT_HOLDS(a_ack_count, clock, reset, $countones(ack_map_ff) == int'(acked_ff))
   // No packet beyond the loaded count is ever marked acked.
   `SRSW_ASSERT_HOLDS(a_ack_in_window, clock, reset, (ack_map_ff & ~vmask) == '0)
   // Acks never outnumber packets.
   `SRSW_ASSERT_HOLDS(a_acked_bound, clock, reset, acked_ff <= total_ff)
   // A load transfer always starts the packet split.
   `SRSW_ASSERT_NEXT(a_load_divides, clock, reset, load_fire, state_ff == srsw_pkg::ST_DIVIDE)

endmodule
